// File: rtl/twfm_pkg.sv
// shared types and constants of the target window first match block
package twfm_pkg;

  // input field widths
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned TRT_W     = 26;
  localparam int unsigned MZ_W      = 32;
  localparam int unsigned SRT_W     = 32;
  // doubled target time, 120 * t
  localparam int unsigned T2_W      = 33;
  // signed bound widths
  localparam int unsigned RT_BND_W  = 35;
  localparam int unsigned MZ_BND_W  = 34;

  // configuration widths
  localparam int unsigned WIN_W     = 22;
  localparam int unsigned TOL_W     = 24;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 24;

  localparam int unsigned STATUS_W  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RT_WINDOW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MZ_HALF_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT  = 2'd2;

  // register reset values
  localparam logic [WIN_W-1:0] RT_WINDOW_RST     = 22'd30000;
  localparam logic [TOL_W-1:0] MZ_HALF_WIDTH_RST = 24'd6554;
  localparam logic [CNT_W-1:0] TARGET_COUNT_RST  = 11'd0;

  // item commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_MATCH   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOPREC  = 2'd2;

  typedef struct packed {
    logic [WIN_W-1:0] rt_window_ms;
    logic [TOL_W-1:0] mz_half_width;
    logic [CNT_W-1:0] target_count;
  } cfg_t;

  // one table entry, time kept already scaled by 120
  typedef struct packed {
    logic [T2_W-1:0] t2;
    logic [MZ_W-1:0] mz;
  } entry_t;

endpackage

// File: rtl/twfm_channels.sv
// valid/ready channel interfaces of the target window first match block

interface twfm_item_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [9:0]  entry_index;
  logic [25:0] target_rt_mmin;
  logic [31:0] load_mz;
  logic [31:0] spectrum_rt_ms;
  logic [31:0] precursor_mz;
  logic        has_precursor;

  modport source (
    output valid, cmd, entry_index, target_rt_mmin, load_mz,
           spectrum_rt_ms, precursor_mz, has_precursor,
    input  ready
  );
  modport sink (
    input  valid, cmd, entry_index, target_rt_mmin, load_mz,
           spectrum_rt_ms, precursor_mz, has_precursor,
    output ready
  );
endinterface

interface twfm_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [9:0] match_index;

  modport source (output valid, status, match_index, input ready);
  modport sink (input valid, status, match_index, output ready);
endinterface

interface twfm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/twfm_cfg.sv
// configuration register file
module twfm_cfg import twfm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  twfm_cfg_if.sink        cfg_i,
  output cfg_t            cfg_o
);

  logic [WIN_W-1:0] rt_window_q;
  logic [TOL_W-1:0] mz_half_width_q;
  logic [CNT_W-1:0] target_count_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_window_q     <= RT_WINDOW_RST;
      mz_half_width_q <= MZ_HALF_WIDTH_RST;
      target_count_q  <= TARGET_COUNT_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_RT_WINDOW:     rt_window_q     <= cfg_i.data[WIN_W-1:0];
        REG_MZ_HALF_WIDTH: mz_half_width_q <= cfg_i.data[TOL_W-1:0];
        REG_TARGET_COUNT:  target_count_q  <= cfg_i.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = '{
    rt_window_ms:  rt_window_q,
    mz_half_width: mz_half_width_q,
    target_count:  target_count_q
  };

endmodule

// File: rtl/twfm_store.sv
// target table memory, one write port and one registered read port
module twfm_store import twfm_pkg::*; #(
  parameter int unsigned MAX_TARGETS = 1024,
  parameter int unsigned AW          = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [MAX_TARGETS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/twfm_ctrl.sv
// load and scan sequencer with window compare and result register
module twfm_ctrl import twfm_pkg::*; #(
  parameter int unsigned MAX_TARGETS = 1024,
  parameter int unsigned AW          = 10,
  parameter int unsigned CW          = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  twfm_item_if.sink     item_i,
  twfm_result_if.source result_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output entry_t        mem_wdata_o,
  output logic          mem_re_o,
  output logic [AW-1:0] mem_raddr_o,
  input  entry_t        mem_rdata_i
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESULT} state_e;

  state_e                       state_q;
  logic [CW-1:0]                issue_q;
  logic [CW-1:0]                n_q;
  logic                         rd_v_q;
  logic                         rd_last_q;
  logic [AW-1:0]                cmp_idx_q;
  logic signed [RT_BND_W-1:0]   rt_lo_q, rt_hi_q;
  logic signed [MZ_BND_W-1:0]   mz_lo_q, mz_hi_q;
  logic [STATUS_W-1:0]          res_status_q;
  logic [AW-1:0]                res_idx_q;
  logic                         out_valid_q;
  logic [STATUS_W-1:0]          out_status_q;
  logic [AW-1:0]                out_idx_q;

  logic                         acc;
  logic                         slot_ok;
  logic [AW+IDX_W-1:0]          slot_ext;
  logic [CW-1:0]                n_sat;
  logic signed [RT_BND_W-1:0]   srt2, win_s, rt_lo_d, rt_hi_d;
  logic signed [MZ_BND_W-1:0]   pmz_s, tol_s, mz_lo_d, mz_hi_d;
  logic signed [RT_BND_W-1:0]   t2_s;
  logic signed [MZ_BND_W-1:0]   mz_s;
  logic                         hit;
  logic                         out_free;
  logic                         out_load;
  logic [CW-1:0]                issue_inc;
  logic [AW+IDX_W-1:0]          out_idx_ext;

  assign acc       = item_i.valid && item_i.ready;
  assign item_i.ready = (state_q == S_IDLE);

  // table write on a load transaction; slots beyond the table are dropped
  assign slot_ok   = (32'(item_i.entry_index) < 32'(MAX_TARGETS));
  assign slot_ext  = {{AW{1'b0}}, item_i.entry_index};
  assign mem_we_o  = acc && (item_i.cmd == CMD_LOAD) && slot_ok;
  assign mem_waddr_o = slot_ext[AW-1:0];
  // 120 * t as 128 * t - 8 * t
  assign mem_wdata_o = '{
    t2: {item_i.target_rt_mmin, 7'b0} - {4'b0, item_i.target_rt_mmin, 3'b0},
    mz: item_i.load_mz
  };

  // count saturated to the table size
  always_comb begin
    if (32'(cfg_i.target_count) > 32'(MAX_TARGETS)) begin
      n_sat = CW'(MAX_TARGETS);
    end else begin
      n_sat = CW'(cfg_i.target_count);
    end
  end

  // window bounds on doubled time and on m/z, signed so a low bound may go negative
  assign srt2    = $signed({2'b0, item_i.spectrum_rt_ms, 1'b0});
  assign win_s   = $signed({13'b0, cfg_i.rt_window_ms});
  assign rt_lo_d = srt2 - win_s;
  assign rt_hi_d = srt2 + win_s;
  assign pmz_s   = $signed({2'b0, item_i.precursor_mz});
  assign tol_s   = $signed({10'b0, cfg_i.mz_half_width});
  assign mz_lo_d = pmz_s - tol_s;
  assign mz_hi_d = pmz_s + tol_s;

  assign mem_re_o    = (state_q == S_SCAN) && (issue_q < n_q);
  assign mem_raddr_o = issue_q[AW-1:0];
  assign issue_inc   = issue_q + CW'(1);

  assign t2_s = $signed({2'b0, mem_rdata_i.t2});
  assign mz_s = $signed({2'b0, mem_rdata_i.mz});
  assign hit  = (t2_s >= rt_lo_q) && (t2_s <= rt_hi_q) &&
                (mz_s >= mz_lo_q) && (mz_s <= mz_hi_q);

  assign out_free = !out_valid_q || result_o.ready;
  assign out_load = (state_q == S_RESULT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      issue_q      <= '0;
      n_q          <= '0;
      rd_v_q       <= 1'b0;
      rd_last_q    <= 1'b0;
      cmp_idx_q    <= '0;
      rt_lo_q      <= '0;
      rt_hi_q      <= '0;
      mz_lo_q      <= '0;
      mz_hi_q      <= '0;
      res_status_q <= ST_NOMATCH;
      res_idx_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_NOMATCH;
      out_idx_q    <= '0;
    end else begin
      if (out_load) begin
        out_valid_q  <= 1'b1;
        out_status_q <= res_status_q;
        out_idx_q    <= res_idx_q;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          rd_v_q <= 1'b0;
          if (acc && (item_i.cmd == CMD_QUERY)) begin
            rt_lo_q <= rt_lo_d;
            rt_hi_q <= rt_hi_d;
            mz_lo_q <= mz_lo_d;
            mz_hi_q <= mz_hi_d;
            issue_q <= '0;
            n_q     <= n_sat;
            res_idx_q <= '0;
            if (!item_i.has_precursor) begin
              res_status_q <= ST_NOPREC;
              state_q      <= S_RESULT;
            end else if (n_sat == '0) begin
              res_status_q <= ST_NOMATCH;
              state_q      <= S_RESULT;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_v_q    <= mem_re_o;
          cmp_idx_q <= issue_q[AW-1:0];
          rd_last_q <= (issue_inc == n_q);
          if (mem_re_o) begin
            issue_q <= issue_inc;
          end
          if (rd_v_q) begin
            if (hit) begin
              res_status_q <= ST_MATCH;
              res_idx_q    <= cmp_idx_q;
              state_q      <= S_RESULT;
            end else if (rd_last_q) begin
              res_status_q <= ST_NOMATCH;
              res_idx_q    <= '0;
              state_q      <= S_RESULT;
            end
          end
        end
        S_RESULT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // match index keeps its low ten bits
  assign out_idx_ext          = {{IDX_W{1'b0}}, out_idx_q};
  assign result_o.valid       = out_valid_q;
  assign result_o.status      = out_status_q;
  assign result_o.match_index = out_idx_ext[IDX_W-1:0];

`ifndef SYNTHESIS
  a_write_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == S_IDLE))
    else $error("table written outside idle");

  a_issue_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (issue_q <= n_q))
    else $error("scan read pointer ran past the count");

  a_match_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RESULT) && (res_status_q == ST_MATCH)) |-> (CW'(res_idx_q) < n_q))
    else $error("matched entry outside the searched range");

  a_query_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (item_i.cmd == CMD_QUERY)) |=> (state_q != S_IDLE))
    else $error("query transaction dropped");

  a_result_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |=> out_valid_q)
    else $error("pending result overwritten or dropped");
`endif

endmodule

// File: rtl/target_window_first_match.sv
// top level of the target window first match block
// Loads write one table entry and finish in the cycle they are accepted. A query
// scans entries 0 to min(target_count, MAX_TARGETS)-1 through the single read
// port of the target memory, one entry per cycle, and stops at the first entry
// whose time and m/z fall inside both windows. Its status and index are registered
// and move into the output register once it is free; a query without precursor
// or with a zero count skips the scan. A new transaction is taken once the result
// is in the output register, even while it waits to be taken. The memory needs no
// clearing after reset if only loaded entries are searched: the user must keep the
// count within the loaded entries, the block itself does not enforce it.
module target_window_first_match import twfm_pkg::*; #(
  parameter int unsigned MAX_TARGETS = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  twfm_cfg_if.sink      cfg_i,
  twfm_item_if.sink     item_i,
  twfm_result_if.source result_o
);

  localparam int unsigned AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int unsigned CW = $clog2(MAX_TARGETS + 1);

  cfg_t          cfg;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  twfm_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  twfm_store #(
    .MAX_TARGETS (MAX_TARGETS),
    .AW          (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  twfm_ctrl #(
    .MAX_TARGETS (MAX_TARGETS),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_i      (item_i),
    .result_o    (result_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule

// File: tb/sv/target_window_first_match_tb.sv
`timescale 1ns / 1ps
// testbench of the target window first match block: directed and random loads and queries
module target_window_first_match_tb;
  import twfm_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 1024;
  localparam int unsigned DEEP_SLOTS   = 256;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned WIN_MAX_MS   = 3600000;
  localparam int unsigned TOL_MAX      = 24'hFFFFFF;
  localparam int unsigned COUNT_MAX    = 2047;
  localparam longint      MMIN_MS      = 60;   // ms per milliminute
  localparam longint      U32_MAX      = 64'h0000_0000_FFFF_FFFF;
  localparam longint      U26_MAX      = 64'h0000_0000_03FF_FFFF;
  localparam logic [TRT_W-1:0] TRT_MAX = '1;
  localparam logic [MZ_W-1:0]  MZ_MAX  = '1;

  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  entry_index;
    logic [TRT_W-1:0]  target_rt_mmin;
    logic [MZ_W-1:0]   load_mz;
    logic [SRT_W-1:0]  spectrum_rt_ms;
    logic [MZ_W-1:0]   precursor_mz;
    logic              has_precursor;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    match_index;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  twfm_cfg_if    cfg_ch();
  twfm_item_if   item_ch();
  twfm_result_if result_ch();

  target_window_first_match #(
    .MAX_TARGETS(TABLE_DEPTH)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_ch),
    .item_i  (item_ch),
    .result_o(result_ch)
  );

  always #5 clk_i = ~clk_i;

  // mirror of the target table and the registers
  logic [TRT_W-1:0] tgt_time   [TABLE_DEPTH];
  logic [MZ_W-1:0]  tgt_mz     [TABLE_DEPTH];
  bit               tgt_loaded [TABLE_DEPTH];
  int               loaded_prefix = 0;
  logic [WIN_W-1:0] win_ms       = RT_WINDOW_RST;
  logic [TOL_W-1:0] mz_tol       = MZ_HALF_WIDTH_RST;
  logic [CNT_W-1:0] search_count = TARGET_COUNT_RST;

  outcome_t expected_results[$];

  int fail_count   = 0;
  int load_count   = 0;
  int query_count  = 0;
  int hit_count    = 0;
  int miss_count   = 0;
  int noprec_count = 0;
  bit source_steady = 1'b0;
  bit sink_steady   = 1'b0;

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v < 0) return '0;
    if (v > U32_MAX) return '1;
    return v[31:0];
  endfunction

  function automatic logic [TRT_W-1:0] clamp26(longint v);
    if (v < 0) return '0;
    if (v > U26_MAX) return '1;
    return v[TRT_W-1:0];
  endfunction

  // offset that often lands right on or just past a window edge
  function automatic longint edge_offset(longint half);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return longint'($urandom_range(0, 32'(2 * half + 2))) - half - 1;
    if (pick < 8) begin
      case ($urandom_range(0, 3))
        0: return -half - 1;
        1: return -half;
        2: return half;
        default: return half + 1;
      endcase
    end
    return 0;
  endfunction

  // first entry inside both windows, -1 if none; flags a scan that reaches an empty slot
  function automatic int first_hit_index(logic [SRT_W-1:0] srt, logic [MZ_W-1:0] pmz,
                                         output bit unloaded_hit);
    longint rt_lo, rt_hi, mz_lo, mz_hi, t2, m;
    int n;
    unloaded_hit = 1'b0;
    rt_lo = 2 * longint'(srt) - longint'(win_ms);
    rt_hi = 2 * longint'(srt) + longint'(win_ms);
    mz_lo = longint'(pmz) - longint'(mz_tol);
    mz_hi = longint'(pmz) + longint'(mz_tol);
    n = (int'(search_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(search_count);
    for (int i = 0; i < n; i++) begin
      if (!tgt_loaded[i]) begin
        unloaded_hit = 1'b1;
        return -1;
      end
      t2 = 2 * MMIN_MS * longint'(tgt_time[i]);
      m = longint'(tgt_mz[i]);
      if (t2 >= rt_lo && t2 <= rt_hi && m >= mz_lo && m <= mz_hi) return i;
    end
    return -1;
  endfunction

  // update the table mirror or queue the result a transaction causes
  function automatic void apply_item(item_t it);
    outcome_t outcome;
    bit unloaded_hit;
    int hit;
    if (it.cmd == CMD_LOAD) begin
      tgt_time[it.entry_index] = it.target_rt_mmin;
      tgt_mz[it.entry_index] = it.load_mz;
      tgt_loaded[it.entry_index] = 1'b1;
      while (loaded_prefix < TABLE_DEPTH && tgt_loaded[loaded_prefix]) loaded_prefix++;
      load_count++;
      return;
    end
    query_count++;
    outcome.match_index = '0;
    if (!it.has_precursor) begin
      outcome.status = ST_NOPREC;
      noprec_count++;
    end else begin
      hit = first_hit_index(it.spectrum_rt_ms, it.precursor_mz, unloaded_hit);
      if (hit >= 0) begin
        outcome.status = ST_MATCH;
        outcome.match_index = IDX_W'(hit);
        hit_count++;
      end else begin
        outcome.status = ST_NOMATCH;
        miss_count++;
      end
    end
    expected_results = {expected_results, outcome};
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.cmd            = 1'($urandom);
    it.entry_index    = IDX_W'($urandom);
    it.target_rt_mmin = TRT_W'($urandom);
    it.load_mz        = $urandom();
    it.spectrum_rt_ms = $urandom();
    it.precursor_mz   = $urandom();
    it.has_precursor  = 1'($urandom);
    return it;
  endfunction

  function automatic item_t load_item(int idx, logic [TRT_W-1:0] t, logic [MZ_W-1:0] mz);
    item_t it;
    it = random_item();
    it.cmd = CMD_LOAD;
    it.entry_index = IDX_W'(idx);
    it.target_rt_mmin = t;
    it.load_mz = mz;
    return it;
  endfunction

  function automatic item_t query_item(logic [SRT_W-1:0] srt, logic [MZ_W-1:0] pmz,
                                       logic has_prec);
    item_t it;
    it = random_item();
    it.cmd = CMD_QUERY;
    it.spectrum_rt_ms = srt;
    it.precursor_mz = pmz;
    it.has_precursor = has_prec;
    return it;
  endfunction

  // query centered on entry k; the scan ends there at the latest
  function automatic item_t exact_query(int k);
    return query_item(clamp32(MMIN_MS * longint'(tgt_time[k])), tgt_mz[k], 1'b1);
  endfunction

  function automatic item_t random_load(logic [TRT_W-1:0] anchor_t,
                                        logic [MZ_W-1:0] anchor_mz);
    item_t it;
    int unsigned pick;
    it = random_item();
    it.cmd = CMD_LOAD;
    pick = $urandom_range(0, 9);
    if (pick < 5 && loaded_prefix < TABLE_DEPTH)
      it.entry_index = IDX_W'(loaded_prefix);
    else if (pick < 8 && loaded_prefix > 0)
      it.entry_index = IDX_W'($urandom_range(0, loaded_prefix - 1));
    // clustered entries make several targets fall inside one window
    if ($urandom_range(0, 1) == 1) begin
      it.target_rt_mmin = clamp26(longint'(anchor_t) +
                                  longint'($urandom_range(0, win_ms / 60 + 4)));
      it.load_mz = clamp32(longint'(anchor_mz) + edge_offset(2 * longint'(mz_tol) + 2));
    end
    return it;
  endfunction

  function automatic item_t random_query(logic [TRT_W-1:0] anchor_t,
                                         logic [MZ_W-1:0] anchor_mz);
    item_t it;
    int unsigned pick;
    int k, hit;
    bit unloaded_hit;
    it = query_item($urandom(), $urandom(), 1'b1);
    pick = $urandom_range(0, 9);
    if (pick < 6 && loaded_prefix > 0) begin
      k = $urandom_range(0, loaded_prefix - 1);
      it.spectrum_rt_ms = clamp32(MMIN_MS * longint'(tgt_time[k]) +
                                  edge_offset(longint'(win_ms) / 2));
      it.precursor_mz = clamp32(longint'(tgt_mz[k]) + edge_offset(longint'(mz_tol)));
    end else if (pick < 9) begin
      it.spectrum_rt_ms = clamp32(MMIN_MS * longint'(anchor_t) + edge_offset(longint'(win_ms)));
      it.precursor_mz = clamp32(longint'(anchor_mz) + edge_offset(2 * longint'(mz_tol)));
    end
    // never let a scan run into a slot that was not loaded
    hit = first_hit_index(it.spectrum_rt_ms, it.precursor_mz, unloaded_hit);
    if (unloaded_hit) begin
      if (loaded_prefix > 0) it = exact_query($urandom_range(0, loaded_prefix - 1));
      else it.has_precursor = 1'b0;
    end
    return it;
  endfunction

  // valid is left high so back-to-back transactions need no extra step
  task automatic send_item(item_t it);
    int gap;
    gap = source_steady ? 0 : pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_ch.valid          <= 1'b1;
    item_ch.cmd            <= it.cmd;
    item_ch.entry_index    <= it.entry_index;
    item_ch.target_rt_mmin <= it.target_rt_mmin;
    item_ch.load_mz        <= it.load_mz;
    item_ch.spectrum_rt_ms <= it.spectrum_rt_ms;
    item_ch.precursor_mz   <= it.precursor_mz;
    item_ch.has_precursor  <= it.has_precursor;
    do @(posedge clk_i); while (!item_ch.ready);
    apply_item(it);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      REG_RT_WINDOW:     win_ms = value[WIN_W-1:0];
      REG_MZ_HALF_WIDTH: mz_tol = value[TOL_W-1:0];
      REG_TARGET_COUNT:  search_count = value[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_windows(int unsigned win, int unsigned tol, int unsigned count);
    write_reg(REG_RT_WINDOW, CFG_DAT_W'(win));
    write_reg(REG_MZ_HALF_WIDTH, CFG_DAT_W'(tol));
    write_reg(REG_TARGET_COUNT, CFG_DAT_W'(count));
  endtask

  // reset values: count is zero, so every query with a precursor misses
  task automatic test_reset_defaults();
    send_item(load_item(TABLE_DEPTH - 1, TRT_MAX, MZ_MAX));
    send_item(query_item(MZ_MAX, MZ_MAX, 1'b1));
    send_item(query_item($urandom(), $urandom(), 1'b0));
    wait_idle();
  endtask

  task automatic test_window_edges();
    send_item(load_item(0, 26'd1000, 32'd1000000));
    send_item(load_item(1, 26'd2000, 32'd2000000));
    send_item(load_item(2, 26'd2000, 32'd2000000));   // duplicate, entry 1 must win
    send_item(load_item(3, '0, '0));
    send_item(load_item(4, TRT_MAX, MZ_MAX));
    wait_idle();
    set_windows(1000, 100, 5);
    // entry 1 sits at 240000 doubled ms, time bounds 119500 and 120500
    send_item(query_item(32'd119500, 32'd2000000, 1'b1));
    send_item(query_item(32'd119499, 32'd2000000, 1'b1));
    send_item(query_item(32'd120500, 32'd2000000, 1'b1));
    send_item(query_item(32'd120501, 32'd2000000, 1'b1));
    send_item(query_item(32'd120000, 32'd1999900, 1'b1));
    send_item(query_item(32'd120000, 32'd1999899, 1'b1));
    send_item(query_item(32'd120000, 32'd2000100, 1'b1));
    send_item(query_item(32'd120000, 32'd2000101, 1'b1));
    // lower bounds below zero
    send_item(query_item('0, '0, 1'b1));
    send_item(query_item(32'd4026531780, MZ_MAX, 1'b1));
    send_item(query_item(32'd120000, 32'd2000000, 1'b0));
    wait_idle();
    // zero windows, count above the table depth
    set_windows(0, 0, COUNT_MAX);
    send_item(query_item(32'd4026531780, MZ_MAX, 1'b1));
    send_item(query_item(32'd60000, 32'd1000000, 1'b1));
    wait_idle();
    set_windows(WIN_MAX_MS, TOL_MAX, TABLE_DEPTH);
    send_item(query_item('0, '0, 1'b1));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int sent, phase_len, count;
    int unsigned pick, win, tol;
    item_t it;
    logic [TRT_W-1:0] anchor_t;
    logic [MZ_W-1:0]  anchor_mz;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      source_steady = ($urandom_range(0, 4) == 0);
      sink_steady = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 5))
        0: win = 0;
        1: win = WIN_MAX_MS;
        2: win = $urandom_range(1, 2000);
        3: win = $urandom_range(1, WIN_MAX_MS);
        default: win = $urandom_range(1000, 60000);
      endcase
      case ($urandom_range(0, 5))
        0: tol = 0;
        1: tol = TOL_MAX;
        2: tol = $urandom_range(1, 200);
        3: tol = $urandom_range(0, TOL_MAX);
        default: tol = $urandom_range(100, 20000);
      endcase
      // mostly short scans, a few phases search the whole table
      case ($urandom_range(0, 9))
        0: count = 0;
        1: count = TABLE_DEPTH;
        2: count = COUNT_MAX;
        3: count = $urandom_range(0, COUNT_MAX);
        4: count = loaded_prefix;
        default: count = $urandom_range(1, loaded_prefix < 44 ? loaded_prefix + 4 : 48);
      endcase
      set_windows(win, tol, count);
      anchor_t = TRT_W'($urandom);
      anchor_mz = $urandom();
      phase_len = $urandom_range(30, 70);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          it = random_load(anchor_t, anchor_mz);
        end else if (pick < 45) begin
          it = query_item($urandom(), $urandom(), 1'b0);
        end else begin
          it = random_query(anchor_t, anchor_mz);
        end
        send_item(it);
        sent++;
      end
    end
    wait_idle();
  endtask

  // every slot below DEEP_SLOTS loaded, so scans may run deep into the table
  task automatic test_deep_scan();
    source_steady = 1'b0;
    sink_steady = 1'b0;
    for (int slot = 0; slot < DEEP_SLOTS; slot++) begin
      if (!tgt_loaded[slot]) send_item(load_item(slot, TRT_W'($urandom), $urandom()));
    end
    wait_idle();
    set_windows($urandom_range(0, 2000), $urandom_range(0, 200), DEEP_SLOTS);
    repeat (4) send_item(query_item($urandom(), $urandom(), 1'b1));
    send_item(exact_query(DEEP_SLOTS - 1));
    wait_idle();
    // count above the table depth, each scan stops inside the loaded prefix
    set_windows($urandom_range(0, 2000), $urandom_range(0, 200), COUNT_MAX);
    repeat (3) send_item(exact_query($urandom_range(0, loaded_prefix - 1)));
    send_item(query_item($urandom(), $urandom(), 1'b0));
    wait_idle();
  endtask

  // result checker
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d, match_index %0d",
               result_ch.status, result_ch.match_index);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, result_ch.status);
          fail_count++;
        end
        if (result_ch.match_index !== want.match_index) begin
          $error("match_index: expected %0d, actual %0d",
                 want.match_index, result_ch.match_index);
          fail_count++;
        end
      end
    end
  end

  // result back-pressure
  initial begin
    int hold;
    int stall;
    hold = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (sink_steady) begin
        result_ch.ready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          result_ch.ready <= 1'b1;
          hold = $urandom_range(0, 6);
        end else begin
          result_ch.ready <= 1'b0;
          hold = stall - 1;
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    item_ch.valid = 1'b0;
    item_ch.cmd = CMD_LOAD;
    item_ch.entry_index = '0;
    item_ch.target_rt_mmin = '0;
    item_ch.load_mz = '0;
    item_ch.spectrum_rt_ms = '0;
    item_ch.precursor_mz = '0;
    item_ch.has_precursor = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_RT_WINDOW;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_window_edges();
    test_random_traffic();
    test_deep_scan();
    $display("%0d queries checked (%0d matched, %0d missed, %0d without precursor), %0d loads",
             query_count, hit_count, miss_count, noprec_count, load_count);
    $display("window, tolerance and count swept to their extremes, scans over %0d entries",
             DEEP_SLOTS);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
